@@ design/ulb_pkg.sv @@
`default_nettype none

package ulb_pkg;

  localparam logic [7:0] BYTE_CR = 8'd13;
  localparam logic [7:0] BYTE_LF = 8'd10;

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = 2;

  typedef enum logic [1:0] {
    REASON_NEWLINE = 2'd0,
    REASON_WIDTH   = 2'd1,
    REASON_END     = 2'd2
  } reason_t;

  typedef struct packed {
    logic [31:0] line_start;
    logic [13:0] line_length;
    reason_t     end_reason;
    logic        last_of_run;
  } result_t;

  // results of one byte, in order
  typedef struct packed {
    logic [1:0] count;
    result_t    first;
    result_t    second;
  } push_t;

endpackage

`default_nettype wire

@@ design/ulb_core.sv @@
`default_nettype none

module ulb_core #(
  parameter int BUFFER_BYTES = 8192
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic [11:0]          view_width,
  input  wire logic [7:0]           wide_width,
  input  wire logic [31:0]          base_offset,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic [7:0]           text_byte,
  input  wire logic [7:0]           glyph_width,
  input  wire logic                 last_byte,
  input  wire logic                 room,
  output ulb_pkg::push_t            push
);

  localparam int PW = $clog2(BUFFER_BYTES);

  logic             s_valid;
  logic [7:0]       s_byte;
  logic [7:0]       s_glyph;
  logic             s_last;
  logic             fire;

  logic [PW-1:0]    pos;
  logic [PW-1:0]    len;
  logic [12:0]      wid;
  logic [1:0]       absorb;
  logic             crp;

  logic [PW-1:0]    pos_next;
  logic [PW-1:0]    len_next;
  logic [12:0]      wid_next;
  logic [1:0]       absorb_next;
  logic             crp_next;

  ulb_pkg::result_t res [2];
  logic [1:0]       n;

  function automatic ulb_pkg::result_t make_result(input logic [31:0] start,
                                                   input logic [PW:0] length,
                                                   input ulb_pkg::reason_t r);
    ulb_pkg::result_t x;
    x.line_start  = start;
    x.line_length = 14'(length);
    x.end_reason  = r;
    x.last_of_run = 1'b0;
    return x;
  endfunction

  assign fire     = s_valid && room;
  assign in_ready = !s_valid || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
    end else if (in_ready) begin
      s_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s_byte  <= text_byte;
      s_glyph <= glyph_width;
      s_last  <= last_byte;
    end
  end

  always_comb begin
    logic [PW:0] pos_w;
    logic [PW:0] len_w;
    logic [12:0] wid_w;
    logic [13:0] sum;
    logic [7:0]  cw;
    logic        last;
    logic        done;
    logic        ascii;
    logic        lead2;
    logic        lead3;

    pos_w       = {1'b0, pos};
    len_w       = {1'b0, len};
    wid_w       = wid;
    absorb_next = absorb;
    crp_next    = crp;
    done        = 1'b0;
    n           = 2'd0;
    res[0]      = '0;
    res[1]      = '0;
    last        = s_last || (pos >= PW'(BUFFER_BYTES - 1));
    ascii       = !s_byte[7];
    lead2       = s_byte[7:5] == 3'b110;
    lead3       = s_byte[7:4] == 4'b1110;
    cw          = ascii ? s_glyph : wide_width;
    sum         = '0;

    if (crp) begin
      crp_next = 1'b0;
      if (s_byte == ulb_pkg::BYTE_LF) begin
        pos_w = pos_w + 1'b1;
        len_w = len_w + 1'b1;
        done  = 1'b1;
      end
      res[n[0]] = make_result(base_offset + 32'(pos_w - len_w), len_w,
                              ulb_pkg::REASON_NEWLINE);
      n     = n + 2'd1;
      len_w = '0;
      wid_w = '0;
    end

    if (!done) begin
      if (absorb != 2'd0) begin
        absorb_next = absorb - 2'd1;
        pos_w       = pos_w + 1'b1;
        len_w       = len_w + 1'b1;
      end else if (s_byte == ulb_pkg::BYTE_CR) begin
        pos_w    = pos_w + 1'b1;
        len_w    = len_w + 1'b1;
        crp_next = 1'b1;
      end else if (s_byte == ulb_pkg::BYTE_LF) begin
        pos_w     = pos_w + 1'b1;
        len_w     = len_w + 1'b1;
        res[n[0]] = make_result(base_offset + 32'(pos_w - len_w), len_w,
                                ulb_pkg::REASON_NEWLINE);
        n         = n + 2'd1;
        len_w     = '0;
        wid_w     = '0;
      end else if (ascii || lead2 || lead3) begin
        sum = {1'b0, wid_w} + {6'd0, cw};
        if (len_w != '0 && sum > {2'd0, view_width}) begin
          res[n[0]] = make_result(base_offset + 32'(pos_w - len_w), len_w,
                                  ulb_pkg::REASON_WIDTH);
          n         = n + 2'd1;
          len_w     = '0;
          wid_w     = '0;
        end
        pos_w = pos_w + 1'b1;
        len_w = len_w + 1'b1;
        sum   = {1'b0, wid_w} + {6'd0, cw};
        wid_w = sum[12:0];
        if (lead2) begin
          absorb_next = 2'd1;
        end else if (lead3) begin
          absorb_next = 2'd2;
        end
      end else begin
        pos_w = pos_w + 1'b1;
        len_w = len_w + 1'b1;
      end
    end

    if (last) begin
      if (crp_next) begin
        crp_next  = 1'b0;
        res[n[0]] = make_result(base_offset + 32'(pos_w - len_w), len_w,
                                ulb_pkg::REASON_NEWLINE);
        n         = n + 2'd1;
      end else if (len_w != '0) begin
        res[n[0]] = make_result(base_offset + 32'(pos_w - len_w), len_w,
                                ulb_pkg::REASON_END);
        n         = n + 2'd1;
      end
      pos_w       = '0;
      len_w       = '0;
      wid_w       = '0;
      absorb_next = 2'd0;
    end

    if (n == 2'd1) begin
      res[0].last_of_run = 1'b1;
    end else if (n == 2'd2) begin
      res[1].last_of_run = 1'b1;
    end

    pos_next = PW'(pos_w);
    len_next = PW'(len_w);
    wid_next = wid_w;
  end

  always_comb begin
    push.count  = fire ? n : 2'd0;
    push.first  = res[0];
    push.second = res[1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos    <= '0;
      len    <= '0;
      wid    <= '0;
      absorb <= '0;
      crp    <= 1'b0;
    end else if (fire) begin
      pos    <= pos_next;
      len    <= len_next;
      wid    <= wid_next;
      absorb <= absorb_next;
      crp    <= crp_next;
    end
  end

  a_len_in_buffer: assert property (@(posedge clk) disable iff (rst)
    len <= pos)
    else $error("open line longer than buffer position");

  a_last_clears: assert property (@(posedge clk) disable iff (rst)
    fire && s_last |=> pos == '0 && len == '0 && absorb == 2'd0 && !crp)
    else $error("state not cleared after end of buffer");

  a_end_is_final: assert property (@(posedge clk) disable iff (rst)
    fire && n == 2'd2 |-> res[0].end_reason != ulb_pkg::REASON_END)
    else $error("end of buffer line not the final result");

endmodule

`default_nettype wire

@@ design/ulb_queue.sv @@
`default_nettype none

module ulb_queue (
  input  wire logic             clk,
  input  wire logic             rst,
  input  ulb_pkg::push_t        push,
  output logic                  room,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output ulb_pkg::result_t      out_data
);

  logic [ulb_pkg::QUEUE_AW-1:0] rd_ptr;
  logic [ulb_pkg::QUEUE_AW-1:0] wr_ptr;
  logic [ulb_pkg::QUEUE_AW:0]   count;
  logic                         pop;
  ulb_pkg::result_t             entries [ulb_pkg::QUEUE_DEPTH];

  assign out_valid = count != '0;
  assign pop       = out_valid && out_ready;
  assign room      = count <= (ulb_pkg::QUEUE_AW + 1)'(ulb_pkg::QUEUE_DEPTH - 2);
  assign out_data  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + ulb_pkg::QUEUE_AW'(push.count);
      rd_ptr <= rd_ptr + ulb_pkg::QUEUE_AW'(pop);
      count  <= count + (ulb_pkg::QUEUE_AW + 1)'(push.count)
                      - (ulb_pkg::QUEUE_AW + 1)'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      entries[wr_ptr] <= push.first;
    end
    if (push.count == 2'd2) begin
      entries[wr_ptr + 1'b1] <= push.second;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    count <= (ulb_pkg::QUEUE_AW + 1)'(ulb_pkg::QUEUE_DEPTH))
    else $error("result queue overflow");

  a_push_has_room: assert property (@(posedge clk) disable iff (rst)
    push.count != 2'd0 |-> room)
    else $error("results pushed without room");

endmodule

`default_nettype wire

@@ design/utf8_greedy_line_breaker.sv @@
// Greedy UTF-8 line breaker. One text byte is taken per cycle on the s_ side unless the
// input stage stalls; each finished display line comes out as one request on the m_ side
// with its start offset, byte length and end reason, tlast marking the last line caused
// by a byte. A byte passes an input register and is resolved once the queue has room;
// its lines are then written into the queue. Lines drain from a four-entry queue one per
// cycle while m_tready is high; the input stage stalls while that queue holds more than
// two lines. Configuration writes take effect at once and belong between buffers.
`default_nettype none

module utf8_greedy_line_breaker #(
  parameter int BUFFER_BYTES = 8192
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_wr_en,
  input  wire logic [1:0]  cfg_addr,
  input  wire logic [31:0] cfg_wr_data,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [15:0] s_tdata,    // text_byte, glyph_width
  input  wire logic        s_tlast,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [47:0]      m_tdata,    // line_start, line_length, end_reason
  output logic             m_tlast
);

  localparam logic [1:0] REG_VIEW_WIDTH  = 2'd0;
  localparam logic [1:0] REG_WIDE_WIDTH  = 2'd1;
  localparam logic [1:0] REG_BASE_OFFSET = 2'd2;

  logic [11:0]      view_width;
  logic [7:0]       wide_width;
  logic [31:0]      base_offset;
  logic             room;
  ulb_pkg::push_t   push;
  ulb_pkg::result_t head;

  always_ff @(posedge clk) begin
    if (rst) begin
      view_width  <= '0;
      wide_width  <= '0;
      base_offset <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_addr)
        REG_VIEW_WIDTH:  view_width  <= cfg_wr_data[11:0];
        REG_WIDE_WIDTH:  wide_width  <= cfg_wr_data[7:0];
        REG_BASE_OFFSET: base_offset <= cfg_wr_data;
        default: ;
      endcase
    end
  end

  ulb_core #(
    .BUFFER_BYTES(BUFFER_BYTES)
  ) u_core (
    .clk         (clk),
    .rst         (rst),
    .view_width  (view_width),
    .wide_width  (wide_width),
    .base_offset (base_offset),
    .in_valid    (s_tvalid),
    .in_ready    (s_tready),
    .text_byte   (s_tdata[7:0]),
    .glyph_width (s_tdata[15:8]),
    .last_byte   (s_tlast),
    .room        (room),
    .push        (push)
  );

  ulb_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .room      (room),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (head)
  );

  assign m_tdata = {head.end_reason, head.line_length, head.line_start};
  assign m_tlast = head.last_of_run;

endmodule

`default_nettype wire

@@ tb/line_breaker_checker.sv @@
`timescale 1ns / 1ps

package line_breaker_tb_pkg;

  localparam logic [1:0] REG_VIEW_WIDTH  = 2'd0;
  localparam logic [1:0] REG_WIDE_WIDTH  = 2'd1;
  localparam logic [1:0] REG_BASE_OFFSET = 2'd2;
  localparam logic [1:0] REG_UNUSED      = 2'd3;

  localparam logic [7:0] BYTE_TAB = 8'd9;

endpackage

module line_breaker_checker #(
  parameter int BUFFER_BYTES = 8192
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_addr,
  input  logic [31:0] cfg_wr_data,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [15:0] s_tdata,    // text_byte, glyph_width
  input  logic        s_tlast,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [47:0] m_tdata,    // line_start, line_length, end_reason
  input  logic        m_tlast,
  output int          errors,
  output int          pending
);

  logic [11:0] view_width;
  logic [7:0]  wide_width;
  logic [31:0] base_offset;

  logic [13:0] buf_pos;
  logic [13:0] line_len;
  logic [12:0] line_wid;
  logic [1:0]  owed;
  logic        cr_held;

  ulb_pkg::result_t lines_due[$];
  ulb_pkg::result_t step_lines[$];

  initial begin
    errors = 0;
    pending = 0;
  end

  task automatic close_line(input ulb_pkg::reason_t why);
    ulb_pkg::result_t r;
    r.line_start  = base_offset + 32'(buf_pos - line_len);
    r.line_length = line_len;
    r.end_reason  = why;
    r.last_of_run = 1'b0;
    step_lines.push_back(r);
    line_len = '0;
    line_wid = '0;
  endtask

  task automatic take_byte();
    line_len = line_len + 1'b1;
    buf_pos  = buf_pos + 1'b1;
  endtask

  task automatic predict_lines(input logic [7:0] b, input logic [7:0] g, input logic last_in);
    logic        at_end;
    logic        finished;
    int unsigned cw;
    at_end = last_in || (int'(buf_pos) >= BUFFER_BYTES - 1);
    finished = 1'b0;
    step_lines = {};
    if (cr_held) begin
      cr_held = 1'b0;
      if (b == ulb_pkg::BYTE_LF) begin
        take_byte();
        close_line(ulb_pkg::REASON_NEWLINE);
        finished = 1'b1;
      end else begin
        close_line(ulb_pkg::REASON_NEWLINE);
      end
    end
    if (!finished) begin
      if (owed != 0) begin
        owed = owed - 1'b1;
        take_byte();
      end else if (b == ulb_pkg::BYTE_CR) begin
        take_byte();
        cr_held = 1'b1;
      end else if (b == ulb_pkg::BYTE_LF) begin
        take_byte();
        close_line(ulb_pkg::REASON_NEWLINE);
      end else if (!b[7] || b[7:5] == 3'b110 || b[7:4] == 4'b1110) begin
        cw = b[7] ? wide_width : g;
        if (line_len != 0 && 32'(line_wid) + cw > 32'(view_width))
          close_line(ulb_pkg::REASON_WIDTH);
        take_byte();
        line_wid = 13'(32'(line_wid) + cw);
        if (b[7:5] == 3'b110)
          owed = 2'd1;
        else if (b[7:4] == 4'b1110)
          owed = 2'd2;
      end else begin
        take_byte();
      end
    end
    if (at_end) begin
      if (cr_held) begin
        cr_held = 1'b0;
        close_line(ulb_pkg::REASON_NEWLINE);
      end else if (line_len != 0) begin
        close_line(ulb_pkg::REASON_END);
      end
      buf_pos  = '0;
      line_len = '0;
      line_wid = '0;
      owed     = '0;
    end
    if (step_lines.size() > 0)
      step_lines[step_lines.size() - 1].last_of_run = 1'b1;
    foreach (step_lines[i])
      lines_due.push_back(step_lines[i]);
  endtask

  always @(posedge clk) begin
    ulb_pkg::result_t want;
    ulb_pkg::result_t got;
    if (rst) begin
      view_width  = '0;
      wide_width  = '0;
      base_offset = '0;
      buf_pos     = '0;
      line_len    = '0;
      line_wid    = '0;
      owed        = '0;
      cr_held     = 1'b0;
      lines_due   = {};
    end else begin
      if (cfg_wr_en) begin
        case (cfg_addr)
          line_breaker_tb_pkg::REG_VIEW_WIDTH:  view_width  = cfg_wr_data[11:0];
          line_breaker_tb_pkg::REG_WIDE_WIDTH:  wide_width  = cfg_wr_data[7:0];
          line_breaker_tb_pkg::REG_BASE_OFFSET: base_offset = cfg_wr_data;
          default: ;
        endcase
      end
      if (s_tvalid && s_tready)
        predict_lines(s_tdata[7:0], s_tdata[15:8], s_tlast);
      if (m_tvalid && m_tready) begin
        got.line_start  = m_tdata[31:0];
        got.line_length = m_tdata[45:32];
        got.end_reason  = ulb_pkg::reason_t'(m_tdata[47:46]);
        got.last_of_run = m_tlast;
        if (lines_due.size() == 0) begin
          errors++;
          $display("%0t: unexpected line: expected none", $realtime);
          $display("%0t:   actual start=%h length=%0d reason=%0d last=%b",
                   $realtime, got.line_start, got.line_length, got.end_reason,
                   got.last_of_run);
        end else begin
          want = lines_due.pop_front();
          if (got.line_start != want.line_start || got.line_length != want.line_length ||
              got.end_reason != want.end_reason || got.last_of_run != want.last_of_run) begin
            errors++;
            $display("%0t: line mismatch: expected start=%h length=%0d reason=%0d last=%b",
                     $realtime, want.line_start, want.line_length, want.end_reason,
                     want.last_of_run);
            $display("%0t:                  actual start=%h length=%0d reason=%0d last=%b",
                     $realtime, got.line_start, got.line_length, got.end_reason,
                     got.last_of_run);
          end
        end
      end
    end
    pending = lines_due.size();
  end

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps

module tb;

  localparam int BUFFER_BYTES  = 8192;
  localparam int STALL_MAX     = 14;
  localparam int SETTLE_CYCLES = 8;
  localparam int QUIET_LIMIT   = 4000;

  localparam logic [7:0] CR = ulb_pkg::BYTE_CR;
  localparam logic [7:0] LF = ulb_pkg::BYTE_LF;

  typedef struct {
    logic [7:0] code;
    logic [7:0] glyph;
  } text_byte_t;

  logic        clk;
  logic        rst;
  logic        cfg_wr_en;
  logic [1:0]  cfg_addr;
  logic [31:0] cfg_wr_data;
  logic        s_tvalid;
  logic        s_tready;
  logic [15:0] s_tdata;    // text_byte, glyph_width
  logic        s_tlast;
  logic        m_tvalid;
  logic        m_tready;
  logic [47:0] m_tdata;    // line_start, line_length, end_reason
  logic        m_tlast;
  int          errors;
  int          pending;

  text_byte_t  text_q[$];
  int unsigned sent = 0;
  int unsigned glyph_cap = 16;
  bit          tx_calm = 0;
  bit          rx_calm = 0;
  int          quiet_cycles = 0;

  // {last_byte, glyph_width, text_byte}
  logic [16:0] opening_text [25] = '{
    {1'b0, 8'h00, 8'h00}, {1'b0, 8'h03, 8'h41}, {1'b0, 8'hff, 8'h7f},
    {1'b0, 8'h00, LF}, {1'b0, 8'h00, LF},
    {1'b0, 8'h00, CR}, {1'b0, 8'h00, LF},
    {1'b0, 8'h05, CR}, {1'b0, 8'h01, 8'h78},
    {1'b0, 8'h00, 8'hc3}, {1'b0, 8'h00, CR},
    {1'b0, 8'h00, 8'he2}, {1'b0, 8'h00, LF}, {1'b0, 8'h00, 8'hff},
    {1'b0, 8'h00, 8'hdf}, {1'b0, 8'h00, 8'hbf}, {1'b0, 8'h00, LF},
    {1'b0, 8'h00, 8'h80}, {1'b0, 8'h00, 8'hf7}, {1'b0, 8'hc8, 8'h57},
    {1'b0, 8'h00, 8'hef}, {1'b1, 8'h09, 8'h20},
    {1'b1, 8'h00, CR}, {1'b1, 8'h00, LF}, {1'b1, 8'h02, 8'h41}
  };

  utf8_greedy_line_breaker #(
    .BUFFER_BYTES(BUFFER_BYTES)
  ) i_dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_addr   (cfg_addr),
    .cfg_wr_data(cfg_wr_data),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tlast    (s_tlast),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tlast    (m_tlast)
  );

  line_breaker_checker #(
    .BUFFER_BYTES(BUFFER_BYTES)
  ) i_checker (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_addr   (cfg_addr),
    .cfg_wr_data(cfg_wr_data),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tlast    (s_tlast),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tlast    (m_tlast),
    .errors     (errors),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wr_en) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // line receiver with random back-pressure
  initial begin
    int unsigned stall;
    m_tready <= 1'b0;
    @(posedge clk);
    forever begin
      if ($urandom_range(0, 29) == 0)
        rx_calm = !rx_calm;
      stall = rx_calm ? 0 : $urandom_range(0, STALL_MAX);
      if (stall != 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
      while (!m_tvalid) @(posedge clk);
    end
  end

  task automatic send_byte(input logic [7:0] code, input logic [7:0] glyph, input logic last_in);
    int unsigned gap;
    if ($urandom_range(0, 29) == 0)
      tx_calm = !tx_calm;
    gap = tx_calm ? 0 : $urandom_range(0, STALL_MAX);
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {glyph, code};
    s_tlast  <= last_in;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sent++;
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic configure(input logic [11:0] vw, input logic [7:0] ww, input logic [31:0] base);
    cfg_wr_en   <= 1'b1;
    cfg_addr    <= line_breaker_tb_pkg::REG_VIEW_WIDTH;
    cfg_wr_data <= {20'($urandom), vw};
    @(posedge clk);
    cfg_addr    <= line_breaker_tb_pkg::REG_WIDE_WIDTH;
    cfg_wr_data <= {24'($urandom), ww};
    @(posedge clk);
    cfg_addr    <= line_breaker_tb_pkg::REG_UNUSED;
    cfg_wr_data <= $urandom;
    @(posedge clk);
    cfg_addr    <= line_breaker_tb_pkg::REG_BASE_OFFSET;
    cfg_wr_data <= base;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    glyph_cap = vw / 4 + 1;
    if (glyph_cap > 255)
      glyph_cap = 255;
  endtask

  function automatic logic [7:0] pick_glyph();
    if ($urandom_range(0, 4) == 0)
      return 8'($urandom_range(0, 255));
    return 8'($urandom_range(0, glyph_cap));
  endfunction

  function automatic void push_byte(input logic [7:0] code, input logic [7:0] glyph);
    text_byte_t t;
    t.code  = code;
    t.glyph = glyph;
    text_q.push_back(t);
  endfunction

  function automatic logic [7:0] tail_byte();
    return 8'($urandom_range(8'h80, 8'hbf));
  endfunction

  function automatic void add_char();
    int unsigned kind;
    kind = $urandom_range(0, 99);
    if (kind < 45) begin
      push_byte(8'($urandom_range(8'h20, 8'h7e)), pick_glyph());
    end else if (kind < 50) begin
      push_byte(line_breaker_tb_pkg::BYTE_TAB, pick_glyph());
    end else if (kind < 58) begin
      push_byte(LF, pick_glyph());
    end else if (kind < 63) begin
      push_byte(CR, pick_glyph());
    end else if (kind < 68) begin
      push_byte(CR, pick_glyph());
      push_byte(LF, pick_glyph());
    end else if (kind < 78) begin
      push_byte(8'($urandom_range(8'hc0, 8'hdf)), pick_glyph());
      push_byte(tail_byte(), pick_glyph());
    end else if (kind < 88) begin
      push_byte(8'($urandom_range(8'he0, 8'hef)), pick_glyph());
      push_byte(tail_byte(), pick_glyph());
      push_byte(tail_byte(), pick_glyph());
    end else if (kind < 91) begin
      push_byte(tail_byte(), pick_glyph());
    end else if (kind < 93) begin
      push_byte(8'($urandom_range(8'hf0, 8'hff)), pick_glyph());
      push_byte(tail_byte(), pick_glyph());
    end else if (kind < 95) begin
      // lead with its tail cut short
      push_byte(8'($urandom_range(8'hc0, 8'hef)), pick_glyph());
    end else begin
      push_byte(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
    end
  endfunction

  task automatic send_buffer(input int unsigned n_chars);
    text_q = {};
    repeat (n_chars) add_char();
    foreach (text_q[i])
      send_byte(text_q[i].code, text_q[i].glyph, i == text_q.size() - 1);
  endtask

  task automatic run_phase(input logic [11:0] vw, input logic [7:0] ww, input logic [31:0] base,
                           input int unsigned n_bytes, input bit hold_midway);
    int unsigned first;
    bit          held;
    wait_drained();
    configure(vw, ww, base);
    first = sent;
    held = 1'b0;
    while (sent - first < n_bytes) begin
      send_buffer($urandom_range(1, 30));
      if (hold_midway && !held && sent - first >= n_bytes / 2) begin
        wait_drained();
        held = 1'b1;
      end
    end
  endtask

  initial begin
    rst         <= 1'b1;
    s_tvalid    <= 1'b0;
    s_tdata     <= '0;
    s_tlast     <= 1'b0;
    cfg_wr_en   <= 1'b0;
    cfg_addr    <= line_breaker_tb_pkg::REG_VIEW_WIDTH;
    cfg_wr_data <= '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    configure(12'd10, 8'd4, 32'hffff_fff0);
    foreach (opening_text[i])
      send_byte(opening_text[i][7:0], opening_text[i][15:8], opening_text[i][16]);
    run_phase(12'd0, 8'd0, 32'h0000_0000, 90, 1'b0);
    run_phase(12'd4095, 8'd255, 32'hffff_ffff, 90, 1'b0);
    run_phase(12'd80, 8'd8, $urandom, 120, 1'b1);
    run_phase(12'($urandom), 8'($urandom), $urandom, 100, 1'b0);
    run_phase(12'd30, 8'd0, 32'h0000_1000, 90, 1'b0);
    run_phase(12'd200, 8'd255, $urandom, 110, 1'b0);
    run_phase(12'($urandom_range(1, 64)), 8'($urandom_range(1, 32)), $urandom, 100, 1'b0);
    wait_drained();
    if (errors == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

@@ utf8_greedy_line_breaker.f @@
design/ulb_pkg.sv
design/ulb_core.sv
design/ulb_queue.sv
design/utf8_greedy_line_breaker.sv
tb/line_breaker_checker.sv
tb/tb.sv
